### rtl/core/ptts_pkg.sv
`timescale 1ns / 1ps

package ptts_pkg;

	localparam int TASK_SLOTS = 8;
	localparam int COUNT_BITS = 16;
	localparam int IDX_W      = $clog2(TASK_SLOTS);
	localparam int SLOT_W     = 3;
	localparam int FIELD_W    = 16;
	localparam int MEM_W      = 2 * COUNT_BITS;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_POLL   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_PRESENT = 2'd1,
		ST_ABSENT  = 2'd2,
		ST_NONE    = 2'd3
	} status_t;

	typedef struct packed {
		status_t            status;
		logic [SLOT_W-1:0]  task_id;
		logic               one_shot_done;
	} res_t;

endpackage

### rtl/core/ptts_ram.sv
`timescale 1ns / 1ps

module ptts_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/ptts_ctrl.sv
`timescale 1ns / 1ps

module ptts_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          cmd,
	input  logic [ptts_pkg::SLOT_W-1:0]         slot,
	input  logic [ptts_pkg::FIELD_W-1:0]        period,
	input  logic [ptts_pkg::FIELD_W-1:0]        start_delay,
	output logic                                res_valid,
	input  logic                                res_ok,
	output ptts_pkg::res_t                      res,
	output logic                                mem_we,
	output logic [ptts_pkg::IDX_W-1:0]          mem_waddr,
	output logic [ptts_pkg::MEM_W-1:0]          mem_wdata,
	output logic                                mem_re,
	output logic [ptts_pkg::IDX_W-1:0]          mem_raddr,
	input  logic [ptts_pkg::MEM_W-1:0]          mem_rdata
);

	localparam int CB = ptts_pkg::COUNT_BITS;
	localparam int N  = ptts_pkg::TASK_SLOTS;
	localparam logic [ptts_pkg::IDX_W-1:0] LAST_IDX = ptts_pkg::IDX_W'(N - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TICK,
		S_TICK_LAST,
		S_POLL_RD,
		S_RESP
	} state_t;

	state_t                       state_q;
	logic [ptts_pkg::IDX_W-1:0]   idx_q;
	logic                         tick_vld_s1;
	logic [ptts_pkg::IDX_W-1:0]   idx_s1;
	logic [N-1:0]                 active_q;
	logic [N-1:0]                 ready_q;
	logic [ptts_pkg::IDX_W-1:0]   cursor_q;
	logic [ptts_pkg::IDX_W-1:0]   poll_idx_q;
	ptts_pkg::res_t               res_q;

	ptts_pkg::cmd_t               cmd_in;
	logic                         accept;
	logic                         slot_in_range;
	logic [ptts_pkg::IDX_W-1:0]   sidx;
	logic                         add_ok;
	logic                         hit_found;
	logic [ptts_pkg::IDX_W-1:0]   hit_idx;
	logic [CB-1:0]                cd_rd;
	logic [CB-1:0]                per_rd;
	logic [CB-1:0]                reload;
	logic [CB-1:0]                cd_next;
	logic                         tick_wr;

	assign cmd_in        = ptts_pkg::cmd_t'(cmd);
	assign in_ready      = (state_q == S_IDLE);
	assign accept        = in_valid && in_ready;
	assign slot_in_range = (int'(slot) < N);
	assign sidx          = slot[ptts_pkg::IDX_W-1:0];
	assign add_ok        = accept && (cmd_in == ptts_pkg::CMD_ADD) && slot_in_range
		&& !active_q[sidx];

	// First slot at or above the cursor that is both active and ready.
	always_comb begin
		hit_found = 1'b0;
		hit_idx   = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (active_q[i] && ready_q[i] && (i >= int'(cursor_q))) begin
				hit_found = 1'b1;
				hit_idx   = ptts_pkg::IDX_W'(i);
			end
		end
	end

	// Tick update of the entry read in the previous cycle. A one-shot
	// countdown holds at zero instead of wrapping.
	assign cd_rd   = mem_rdata[CB-1:0];
	assign per_rd  = mem_rdata[ptts_pkg::MEM_W-1:CB];
	assign reload  = (cd_rd == '0) ? per_rd : cd_rd;
	assign cd_next = (reload == '0) ? '0 : reload - CB'(1);
	assign tick_wr = tick_vld_s1 && active_q[idx_s1];

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = {per_rd, cd_next};
		if (tick_wr) begin
			mem_we = 1'b1;
		end else if (add_ok) begin
			mem_we    = 1'b1;
			mem_waddr = sidx;
			mem_wdata = {period[CB-1:0], start_delay[CB-1:0]};
		end
	end

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = hit_idx;
		if (state_q == S_TICK) begin
			mem_re    = 1'b1;
			mem_raddr = idx_q;
		end else if (accept && (cmd_in == ptts_pkg::CMD_POLL) && hit_found) begin
			mem_re = 1'b1;
		end
	end

	assign res_valid = (state_q == S_RESP);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			tick_vld_s1 <= 1'b0;
			idx_s1      <= '0;
			active_q    <= '0;
			ready_q     <= '0;
			cursor_q    <= '0;
			poll_idx_q  <= '0;
			res_q       <= '{status: ptts_pkg::ST_OK, task_id: '0, one_shot_done: 1'b0};
		end else begin
			tick_vld_s1 <= (state_q == S_TICK);
			idx_s1      <= idx_q;
			if (tick_wr && (cd_rd == '0)) begin
				ready_q[idx_s1] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd_in)
							ptts_pkg::CMD_TICK: begin
								res_q   <= '{status: ptts_pkg::ST_OK, task_id: '0,
									one_shot_done: 1'b0};
								idx_q   <= '0;
								state_q <= S_TICK;
							end
							ptts_pkg::CMD_ADD: begin
								if (!slot_in_range) begin
									res_q <= '{status: ptts_pkg::ST_ABSENT, task_id: '0,
										one_shot_done: 1'b0};
								end else if (active_q[sidx]) begin
									res_q <= '{status: ptts_pkg::ST_PRESENT, task_id: '0,
										one_shot_done: 1'b0};
								end else begin
									res_q <= '{status: ptts_pkg::ST_OK, task_id: '0,
										one_shot_done: 1'b0};
									active_q[sidx] <= 1'b1;
									ready_q[sidx]  <= 1'b0;
								end
								state_q <= S_RESP;
							end
							ptts_pkg::CMD_REMOVE: begin
								if (!slot_in_range || !active_q[sidx]) begin
									res_q <= '{status: ptts_pkg::ST_ABSENT, task_id: '0,
										one_shot_done: 1'b0};
								end else begin
									res_q <= '{status: ptts_pkg::ST_OK, task_id: '0,
										one_shot_done: 1'b0};
									active_q[sidx] <= 1'b0;
									ready_q[sidx]  <= 1'b0;
								end
								state_q <= S_RESP;
							end
							default: begin
								if (hit_found) begin
									ready_q[hit_idx] <= 1'b0;
									cursor_q   <= (hit_idx == LAST_IDX) ? '0
										: hit_idx + ptts_pkg::IDX_W'(1);
									poll_idx_q <= hit_idx;
									res_q <= '{status: ptts_pkg::ST_OK,
										task_id: ptts_pkg::SLOT_W'(hit_idx),
										one_shot_done: 1'b0};
									state_q    <= S_POLL_RD;
								end else begin
									cursor_q <= '0;
									res_q    <= '{status: ptts_pkg::ST_NONE, task_id: '0,
										one_shot_done: 1'b0};
									state_q  <= S_RESP;
								end
							end
						endcase
					end
				end
				S_TICK: begin
					if (idx_q == LAST_IDX) begin
						state_q <= S_TICK_LAST;
					end else begin
						idx_q <= idx_q + ptts_pkg::IDX_W'(1);
					end
				end
				S_TICK_LAST: begin
					state_q <= S_RESP;
				end
				S_POLL_RD: begin
					if (per_rd == '0) begin
						active_q[poll_idx_q] <= 1'b0;
						res_q.one_shot_done  <= 1'b1;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (res_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/core/periodic_task_tick_scheduler_top.sv
`timescale 1ns / 1ps

// Periodic task scheduler with eight task slots.
// Requests arrive on the in_valid/in_ready channel with cmd, slot, period and
// start_delay; each request yields exactly one response on out_valid/out_ready
// carrying status, task_id and one_shot_done, in request order.
// Period and countdown of every slot live in a small synchronous RAM with a
// registered read; active and ready marks are flip-flops.
// A tick walks the slots with a read-modify-write pipeline, one slot per cycle,
// and then goes through S_TICK_LAST to S_RESP, which loads its response into the
// output register.
// Add, remove and a poll that finds nothing go straight to S_RESP; a poll
// that finds a ready slot first passes S_POLL_RD (one RAM read for the period).
// One request is in progress at a time; the next is taken once the previous
// response has been loaded into the output register.
// Reset clears all active and ready marks and the poll cursor; no RAM clearing
// pass is needed: RAM data of a slot is only used after an add writes it.
// When the receiver stalls, the response holds in the output register and the
// following request completes internally, then waits until the register frees.
module periodic_task_tick_scheduler_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [2:0]  slot,
	input  logic [15:0] period,
	input  logic [15:0] start_delay,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [2:0]  task_id,
	output logic        one_shot_done
);

	logic                          res_valid;
	logic                          res_ok;
	ptts_pkg::res_t                res;
	logic                          mem_we;
	logic [ptts_pkg::IDX_W-1:0]    mem_waddr;
	logic [ptts_pkg::MEM_W-1:0]    mem_wdata;
	logic                          mem_re;
	logic [ptts_pkg::IDX_W-1:0]    mem_raddr;
	logic [ptts_pkg::MEM_W-1:0]    mem_rdata;
	logic                          out_valid_q;
	ptts_pkg::res_t                out_q;

	assign res_ok = !out_valid_q || out_ready;

	ptts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.slot       (slot),
		.period     (period),
		.start_delay(start_delay),
		.res_valid  (res_valid),
		.res_ok     (res_ok),
		.res        (res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	ptts_ram #(
		.DEPTH(ptts_pkg::TASK_SLOTS),
		.WIDTH(ptts_pkg::MEM_W)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ok) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ok && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign task_id       = out_q.task_id;
	assign one_shot_done = out_q.one_shot_done;

endmodule

### verif/periodic_task_tick_scheduler_top_tb.sv
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_top_tb;
	import ptts_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_REQUESTS = 1100;

	typedef struct {
		cmd_t        op;
		logic [2:0]  slot;
		logic [15:0] period;
		logic [15:0] delay;
	} sched_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = CMD_TICK;
	logic [2:0]  slot = '0;
	logic [15:0] period = '0;
	logic [15:0] start_delay = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [2:0]  task_id;
	logic        one_shot_done;

	periodic_task_tick_scheduler_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.slot          (slot),
		.period        (period),
		.start_delay   (start_delay),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.task_id       (task_id),
		.one_shot_done (one_shot_done)
	);

	// Predicted state of the task table.
	bit                  task_live [TASK_SLOTS];
	bit                  task_due [TASK_SLOTS];
	logic [COUNT_BITS-1:0] task_reload [TASK_SLOTS];
	logic [COUNT_BITS-1:0] task_count [TASK_SLOTS];
	logic [IDX_W-1:0]    poll_at;

	sched_req_t pending_requests[$];
	res_t       due_responses[$];
	sched_req_t cur_req;
	int         accepted_requests;
	int         total_requests;
	int         mismatches;
	int         cycle_count;
	int         in_gap;
	int         in_burst;
	int         out_stall;
	int         out_burst;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic res_t scheduler_response(input sched_req_t rq);
		res_t r;
		bit   hit;
		r = '0;
		hit = 1'b0;
		case (rq.op)
			CMD_TICK: begin
				for (int i = 0; i < TASK_SLOTS; i++) begin
					if (task_live[i]) begin
						if (task_count[i] == 0) begin
							task_due[i] = 1'b1;
							task_count[i] = task_reload[i];
						end
						// A one-shot slot reloads zero and so holds at zero.
						if (task_count[i] != 0)
							task_count[i] = task_count[i] - 1'b1;
					end
				end
				r.status = ST_OK;
			end
			CMD_ADD: begin
				if (rq.slot >= TASK_SLOTS) begin
					r.status = ST_ABSENT;
				end else if (task_live[rq.slot]) begin
					r.status = ST_PRESENT;
				end else begin
					task_live[rq.slot] = 1'b1;
					task_due[rq.slot] = 1'b0;
					task_reload[rq.slot] = rq.period;
					task_count[rq.slot] = rq.delay;
					r.status = ST_OK;
				end
			end
			CMD_REMOVE: begin
				if (rq.slot >= TASK_SLOTS || !task_live[rq.slot]) begin
					r.status = ST_ABSENT;
				end else begin
					task_live[rq.slot] = 1'b0;
					task_due[rq.slot] = 1'b0;
					r.status = ST_OK;
				end
			end
			default: begin
				// The scan does not wrap round; a miss sends the cursor home.
				for (int i = poll_at; i < TASK_SLOTS && !hit; i++) begin
					if (task_live[i] && task_due[i]) begin
						hit = 1'b1;
						task_due[i] = 1'b0;
						r.status = ST_OK;
						r.task_id = 3'(i);
						if (task_reload[i] == 0) begin
							task_live[i] = 1'b0;
							r.one_shot_done = 1'b1;
						end
						poll_at = (i + 1 < TASK_SLOTS) ? IDX_W'(i + 1) : '0;
					end
				end
				if (!hit) begin
					poll_at = '0;
					r.status = ST_NONE;
				end
			end
		endcase
		return r;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] rand_count(input int zero_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < zero_pct)
			return 16'd0;
		else if (r < 65)
			return 16'($urandom_range(1, 4));
		else if (r < 90)
			return 16'($urandom_range(5, 20));
		else
			return 16'($urandom_range(0, 16'hFFFF));
	endfunction

	task automatic push_req(input cmd_t op, input int s, input int per, input int dly);
		sched_req_t rq;
		rq.op = op;
		rq.slot = 3'(s);
		rq.period = 16'(per);
		rq.delay = 16'(dly);
		pending_requests.push_back(rq);
	endtask

	function automatic sched_req_t rand_request();
		sched_req_t rq;
		int         r;
		r = $urandom_range(0, 99);
		if (r < 35)
			rq.op = CMD_TICK;
		else if (r < 57)
			rq.op = CMD_ADD;
		else if (r < 67)
			rq.op = CMD_REMOVE;
		else
			rq.op = CMD_POLL;
		rq.slot = 3'($urandom_range(0, 7));
		rq.period = rand_count(25);
		rq.delay = rand_count(30);
		return rq;
	endfunction

	task automatic compare_field(input string name, input logic [2:0] want,
			input logic [2:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 30)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Request driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			cmd <= CMD_TICK;
			slot <= '0;
			period <= '0;
			start_delay <= '0;
		end else begin
			if (in_valid && in_ready) begin
				due_responses.push_back(scheduler_response(cur_req));
				accepted_requests++;
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					cur_req = pending_requests.pop_front();
					in_valid <= 1'b1;
					cmd <= cur_req.op;
					slot <= cur_req.slot;
					period <= cur_req.period;
					start_delay <= cur_req.delay;
					if (in_burst > 0) begin
						in_burst--;
						in_gap = 0;
					end else begin
						in_gap = idle_len();
						if ($urandom_range(0, 63) == 0)
							in_burst = $urandom_range(20, 60);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor; it also stalls the response channel at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_responses.size() == 0) begin
					mismatches++;
					if (mismatches <= 30)
						$display("%0t: response with none expected, got status %0d task_id %0d done %0d",
							$time, status, task_id, one_shot_done);
				end else begin
					res_t want;
					want = due_responses.pop_front();
					compare_field("status", 3'(want.status), 3'(status));
					compare_field("task_id", want.task_id, task_id);
					compare_field("one_shot_done", 3'(want.one_shot_done),
						3'(one_shot_done));
				end
			end
			if (out_stall > 0) begin
				out_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (out_burst > 0) begin
					out_burst--;
				end else if ((out_valid && out_ready) || $urandom_range(0, 7) == 0) begin
					out_stall = idle_len();
					if ($urandom_range(0, 63) == 0)
						out_burst = $urandom_range(50, 150);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("periodic_task_tick_scheduler_top_tb: FAIL");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < TASK_SLOTS; i++) begin
			task_live[i] = 1'b0;
			task_due[i] = 1'b0;
			task_reload[i] = '0;
			task_count[i] = '0;
		end
		poll_at = '0;

		// Empty table, then a one-shot, a slow periodic slot and a period of one.
		push_req(CMD_POLL, 0, 0, 0);
		push_req(CMD_TICK, 7, 16'hFFFF, 16'hFFFF);
		push_req(CMD_REMOVE, 0, 0, 0);
		push_req(CMD_ADD, 0, 0, 0);
		push_req(CMD_ADD, 0, 5, 5);
		push_req(CMD_ADD, 7, 16'hFFFF, 0);
		push_req(CMD_ADD, 3, 1, 0);
		push_req(CMD_TICK, 0, 0, 0);
		push_req(CMD_POLL, 0, 0, 0);
		push_req(CMD_POLL, 0, 0, 0);
		// Slot 7 is hit here, so the cursor wraps back to zero.
		push_req(CMD_POLL, 0, 0, 0);
		push_req(CMD_POLL, 0, 0, 0);
		push_req(CMD_ADD, 5, 2, 16'hFFFF);
		push_req(CMD_TICK, 0, 0, 0);
		push_req(CMD_ADD, 1, 0, 2);
		push_req(CMD_TICK, 0, 0, 0);
		push_req(CMD_TICK, 0, 0, 0);
		push_req(CMD_TICK, 0, 0, 0);
		push_req(CMD_POLL, 0, 0, 0);
		push_req(CMD_POLL, 0, 0, 0);
		// Slot 3 is ready again but lies behind the cursor, so the poll misses.
		push_req(CMD_TICK, 0, 0, 0);
		push_req(CMD_POLL, 0, 0, 0);
		push_req(CMD_REMOVE, 3, 0, 0);
		push_req(CMD_REMOVE, 7, 0, 0);
		push_req(CMD_REMOVE, 0, 0, 0);

		for (int n = 0; n < RANDOM_REQUESTS; n++)
			pending_requests.push_back(rand_request());
		total_requests = pending_requests.size();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_requests < total_requests || due_responses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("periodic_task_tick_scheduler_top_tb: PASS");
		else
			$display("periodic_task_tick_scheduler_top_tb: FAIL");
		$finish;
	end

endmodule
